### sv/utf8d_pkg.sv
// Package: shared types and constants for the UTF-8 decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam int CP_W  = 21;
	localparam int LEN_W = 3;
	localparam int PND_W = 2;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] CONT_BITS  = 8'h3F;

	localparam logic [LEN_W-1:0] LEN1 = 3'd1;
	localparam logic [LEN_W-1:0] LEN2 = 3'd2;
	localparam logic [LEN_W-1:0] LEN3 = 3'd3;
	localparam logic [LEN_W-1:0] LEN4 = 3'd4;

	typedef struct packed {
		logic [PND_W-1:0] pending;
		logic [CP_W-1:0]  partial;
		logic [LEN_W-1:0] len;
	} dec_state_t;

	typedef struct packed {
		logic             valid;
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_bytes;
	} dec_result_t;

	localparam dec_state_t STATE_IDLE = '{pending: '0, partial: '0, len: '0};

endpackage

### sv/utf8d_step.sv
// Per-byte decode: next sequence state and optional code point.
`timescale 1ns / 1ps

module utf8d_step (
	input  utf8d_pkg::dec_state_t  cur,
	input  logic [7:0]             byte_in,
	input  logic                   last_byte,
	output utf8d_pkg::dec_state_t  nxt,
	output utf8d_pkg::dec_result_t res
);
	import utf8d_pkg::*;

	logic [CP_W-1:0]  shifted;
	logic [PND_W-1:0] pend_dec;
	dec_state_t       upd;

	assign shifted  = {cur.partial[CP_W-7:0], byte_in[5:0]};
	assign pend_dec = cur.pending - PND_W'(1);

	always_comb begin
		upd = cur;
		res.valid = 1'b0;
		res.code_point = CP_W'(byte_in);
		res.seq_bytes = LEN1;
		if (cur.pending == '0) begin
			priority if (!byte_in[7]) begin
				res.valid = 1'b1;
			end else if ((byte_in & LEAD2_MASK) == LEAD2_CODE) begin
				upd.partial = CP_W'(byte_in[4:0]);
				upd.pending = PND_W'(1);
				upd.len = LEN2;
			end else if ((byte_in & LEAD3_MASK) == LEAD3_CODE) begin
				upd.partial = CP_W'(byte_in[3:0]);
				upd.pending = PND_W'(2);
				upd.len = LEN3;
			end else if ((byte_in & LEAD4_MASK) == LEAD4_CODE) begin
				upd.partial = CP_W'(byte_in[2:0]);
				upd.pending = PND_W'(3);
				upd.len = LEN4;
			end else begin
				upd = STATE_IDLE;
			end
		end else if ((byte_in & CONT_MASK) == CONT_CODE) begin
			if (pend_dec == '0) begin
				res.valid = 1'b1;
				res.code_point = shifted;
				res.seq_bytes = cur.len;
				upd = STATE_IDLE;
			end else begin
				upd.partial = shifted;
				upd.pending = pend_dec;
			end
		end else begin
			// broken sequence: drop it and this byte
			upd = STATE_IDLE;
		end
	end

	// end of string discards an open sequence
	assign nxt = (last_byte && upd.pending != '0) ? STATE_IDLE : upd;

endmodule

### sv/utf8d_out_stage.sv
// Result register holding one decoded code point until taken.
`timescale 1ns / 1ps

module utf8d_out_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  utf8d_pkg::dec_result_t     res,
	output logic                       can_load,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [utf8d_pkg::CP_W-1:0]  code_point,
	output logic [utf8d_pkg::LEN_W-1:0] seq_bytes
);
	import utf8d_pkg::*;

	logic             valid_q;
	logic [CP_W-1:0]  cp_q;
	logic [LEN_W-1:0] len_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			cp_q <= res.code_point;
			len_q <= res.seq_bytes;
		end
	end

	assign out_valid  = valid_q;
	assign code_point = cp_q;
	assign seq_bytes  = len_q;

endmodule

### sv/utf8_to_code_point_decoder_unit.sv
// Top level: UTF-8 byte stream to code point decoder.
//
// Input channel: in_valid/in_ready carry one request per byte (byte_in) with
// last_byte marking the final byte of a string; an unfinished sequence is then
// discarded. Output channel: out_valid/out_ready carry one decoded code point
// with seq_bytes, the number of bytes that formed it.
// One byte is accepted per cycle, sustained while the output is not stalled. A
// byte lands in the input register at acceptance; the decode logic then runs
// it against the sequence state and loads the result register once that
// register can take it, and the result register drives the output channel.
// Bytes that complete nothing (lead and continuation bytes mid-sequence,
// dropped bytes) just update the state and produce no output request.
// Reset clears the input and result valids and returns the decoder to idle.
// When the receiver stalls, the result register holds and the input register
// keeps its byte; in_ready drops only while both are full.
`timescale 1ns / 1ps

module utf8_to_code_point_decoder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  byte_in,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [utf8d_pkg::CP_W-1:0]  code_point,
	output logic [utf8d_pkg::LEN_W-1:0] seq_bytes
);
	import utf8d_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        can_load;
	logic        advance;

	assign advance  = valid_s1 && can_load;
	assign in_ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_in;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	utf8d_step u_step (
		.cur       (state_q),
		.byte_in   (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	utf8d_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.res        (res),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_point (code_point),
		.seq_bytes  (seq_bytes)
	);

endmodule
